>>> rtl/fdbl_pkg.sv
// ----------------------------------------------------------------------------
// fdbl_pkg
// Shared constants, types and helpers for the frame difference band locator.
// ----------------------------------------------------------------------------
package fdbl_pkg;

    // Band counts and accumulator width
    localparam int COL_BANDS = 16;
    localparam int ROW_BANDS = 8;
    localparam int SUM_WIDTH = 32;

    localparam int COL_IDX_W = (COL_BANDS > 1) ? $clog2(COL_BANDS) : 1;
    localparam int ROW_IDX_W = (ROW_BANDS > 1) ? $clog2(ROW_BANDS) : 1;

    // Field widths
    localparam int PIX_W     = 8;
    localparam int DIM_W     = 13;
    localparam int POS_W     = 12;
    localparam int OUT_COL_W = 5;
    localparam int OUT_ROW_W = 4;
    localparam int OUT_SUM_W = 32;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_FRAME_WIDTH     = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_COL_BAND_WIDTH  = 2'd2;
    localparam logic [1:0] REG_ROW_BAND_HEIGHT = 2'd3;

    localparam logic [DIM_W-1:0] DIM_MAX             = 13'd4096;
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST     = 13'd1920;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST    = 13'd1080;
    localparam logic [DIM_W-1:0] COL_BAND_WIDTH_RST  = 13'd192;
    localparam logic [DIM_W-1:0] ROW_BAND_HEIGHT_RST = 13'd216;

    typedef logic [PIX_W-1:0]     pix_t;
    typedef logic [DIM_W-1:0]     dim_t;
    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [COL_IDX_W-1:0] col_idx_t;
    typedef logic [ROW_IDX_W-1:0] row_idx_t;
    typedef logic [SUM_WIDTH-1:0] sum_t;

    // Band position of the pixel at the head of the scan
    typedef struct packed {
        col_idx_t col_idx;
        row_idx_t row_idx;
        logic     frame_end;
    } scan_pos_t;

    // One result item
    typedef struct packed {
        logic [OUT_COL_W-1:0] best_col_band;
        logic [OUT_ROW_W-1:0] best_row_band;
        logic [OUT_SUM_W-1:0] best_col_sum;
        logic [OUT_SUM_W-1:0] best_row_sum;
    } res_t;

    // Saturate an accumulator value to the result sum width
    function automatic logic [OUT_SUM_W-1:0] to_out_sum(input sum_t s);
        logic [63:0] wide;
        begin
            wide = 64'(s);
            if (wide > 64'h0000_0000_FFFF_FFFF)
                to_out_sum = '1;
            else
                to_out_sum = wide[OUT_SUM_W-1:0];
        end
    endfunction

endpackage

>>> rtl/frame_difference_band_locator_core.sv
// ----------------------------------------------------------------------------
// frame_difference_band_locator_core
// Motion localization by frame difference: finds the column band and the row
// band with the largest summed absolute pixel difference in each frame.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel channel (pix_valid / pix_stall, cur_pixel, prev_pixel) takes one
//   pixel pair per clock while pix_stall is low, in raster order. Result
//   channel (res_valid / res_stall, best_*) gives one item per frame.
//   Throughput: one pixel per cycle while pix_stall is low. Each pixel
//   does a registered read, then an add and write-back on the band sum
//   memories; a write forwarding register covers back-to-back hits on
//   one band. The result item is formed from the stage 1 registers and
//   written into the output queue, which drives res_valid.
//   Results go through a two-entry output queue, so pixels keep flowing
//   while a result waits. pix_stall rises only when the queue would fill,
//   i.e. when res_stall holds results back.
//   Reset: position counters clear, all band sums read as zero, the
//   configuration returns to 1920x1080 with 192-column and 216-line bands.
//   No clearing pass: band sums restart through per-entry valid bits.
//   The user must write configuration over APB only while no frame is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module frame_difference_band_locator_core
    import fdbl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // pixel pairs
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  logic [PIX_W-1:0]      cur_pixel,
    input  logic [PIX_W-1:0]      prev_pixel,
    // results
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic [OUT_COL_W-1:0]  best_col_band,
    output logic [OUT_ROW_W-1:0]  best_row_band,
    output logic [OUT_SUM_W-1:0]  best_col_sum,
    output logic [OUT_SUM_W-1:0]  best_row_sum
);

    dim_t frame_width_reg;
    dim_t frame_height_reg;
    dim_t col_band_width_reg;
    dim_t row_band_height_reg;

    logic       cfg_wr;
    logic [1:0] cfg_sel;

    logic      accept;
    pix_t      diff;
    scan_pos_t pos;
    logic      res_push;
    res_t      res_data;

    res_t       q_data_reg [2];
    logic       q_wr_ptr_reg;
    logic       q_rd_ptr_reg;
    logic [1:0] q_count_reg;
    logic       q_pop;
    logic [2:0] q_occ_after;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg     <= FRAME_WIDTH_RST;
            frame_height_reg    <= FRAME_HEIGHT_RST;
            col_band_width_reg  <= COL_BAND_WIDTH_RST;
            row_band_height_reg <= ROW_BAND_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                REG_FRAME_WIDTH:     frame_width_reg     <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT:    frame_height_reg    <= pwdata[DIM_W-1:0];
                REG_COL_BAND_WIDTH:  col_band_width_reg  <= pwdata[DIM_W-1:0];
                REG_ROW_BAND_HEIGHT: row_band_height_reg <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_FRAME_WIDTH:     prdata = APB_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT:    prdata = APB_DATA_W'(frame_height_reg);
            REG_COL_BAND_WIDTH:  prdata = APB_DATA_W'(col_band_width_reg);
            REG_ROW_BAND_HEIGHT: prdata = APB_DATA_W'(row_band_height_reg);
            default:             prdata = '0;
        endcase
    end

    // Take a pixel pair and form its absolute difference
    assign accept = pix_valid && !pix_stall;
    assign diff   = (cur_pixel >= prev_pixel) ? (cur_pixel - prev_pixel)
                                              : (prev_pixel - cur_pixel);

    fdbl_scan u_scan (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (accept),
        .frame_width     (frame_width_reg),
        .frame_height    (frame_height_reg),
        .col_band_width  (col_band_width_reg),
        .row_band_height (row_band_height_reg),
        .pos             (pos)
    );

    fdbl_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc_valid (accept),
        .acc_pos   (pos),
        .acc_diff  (diff),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    // Output queue; stall pixels when a pending result could not be stored
    assign res_valid   = (q_count_reg != 2'd0);
    assign q_pop       = res_valid && !res_stall;
    assign q_occ_after = 3'(q_count_reg) + 3'(res_push) - 3'(q_pop);
    assign pix_stall   = (q_occ_after >= 3'd2);

    assign best_col_band = q_data_reg[q_rd_ptr_reg].best_col_band;
    assign best_row_band = q_data_reg[q_rd_ptr_reg].best_row_band;
    assign best_col_sum  = q_data_reg[q_rd_ptr_reg].best_col_sum;
    assign best_row_sum  = q_data_reg[q_rd_ptr_reg].best_row_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= 1'b0;
            q_rd_ptr_reg <= 1'b0;
            q_count_reg  <= 2'd0;
        end
        else
        begin
            if (res_push)
                q_wr_ptr_reg <= ~q_wr_ptr_reg;
            if (q_pop)
                q_rd_ptr_reg <= ~q_rd_ptr_reg;
            q_count_reg <= q_occ_after[1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            q_data_reg[q_wr_ptr_reg] <= res_data;
    end

endmodule

>>> rtl/fdbl_ram.sv
// ----------------------------------------------------------------------------
// fdbl_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module fdbl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/fdbl_scan.sv
// ----------------------------------------------------------------------------
// fdbl_scan
// Raster position counters: tracks line position, band position and band
// indexes, and flags the last pixel of the frame.
// ----------------------------------------------------------------------------
module fdbl_scan
    import fdbl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  dim_t      frame_width,
    input  dim_t      frame_height,
    input  dim_t      col_band_width,
    input  dim_t      row_band_height,
    output scan_pos_t pos
);

    function automatic dim_t clamp_dim(input dim_t v);
        begin
            if (v == '0)
                clamp_dim = DIM_W'(1);
            else if (v > DIM_MAX)
                clamp_dim = DIM_MAX;
            else
                clamp_dim = v;
        end
    endfunction

    pos_t     x_pos_reg, x_pos_next;
    pos_t     x_band_reg, x_band_next;
    col_idx_t col_idx_reg, col_idx_next;
    pos_t     y_pos_reg, y_pos_next;
    pos_t     y_band_reg, y_band_next;
    row_idx_t row_idx_reg, row_idx_next;

    dim_t w, h, cbw, rbh;
    logic line_more, band_x_more, frame_more, band_y_more;

    assign w   = clamp_dim(frame_width);
    assign h   = clamp_dim(frame_height);
    assign cbw = clamp_dim(col_band_width);
    assign rbh = clamp_dim(row_band_height);

    assign line_more   = ({1'b0, x_pos_reg} + DIM_W'(1)) < w;
    assign band_x_more = ({1'b0, x_band_reg} + DIM_W'(1)) < cbw;
    assign frame_more  = ({1'b0, y_pos_reg} + DIM_W'(1)) < h;
    assign band_y_more = ({1'b0, y_band_reg} + DIM_W'(1)) < rbh;

    assign pos.col_idx   = col_idx_reg;
    assign pos.row_idx   = row_idx_reg;
    assign pos.frame_end = !line_more && !frame_more;

    // Step the raster position by one pixel
    always_comb
    begin
        x_pos_next   = x_pos_reg;
        x_band_next  = x_band_reg;
        col_idx_next = col_idx_reg;
        y_pos_next   = y_pos_reg;
        y_band_next  = y_band_reg;
        row_idx_next = row_idx_reg;
        if (advance)
        begin
            if (line_more)
            begin
                x_pos_next = x_pos_reg + 1'b1;
                if (band_x_more)
                    x_band_next = x_band_reg + 1'b1;
                else
                begin
                    x_band_next = '0;
                    if (col_idx_reg != COL_IDX_W'(COL_BANDS - 1))
                        col_idx_next = col_idx_reg + 1'b1;
                end
            end
            else
            begin
                x_pos_next   = '0;
                x_band_next  = '0;
                col_idx_next = '0;
                if (frame_more)
                begin
                    y_pos_next = y_pos_reg + 1'b1;
                    if (band_y_more)
                        y_band_next = y_band_reg + 1'b1;
                    else
                    begin
                        y_band_next = '0;
                        if (row_idx_reg != ROW_IDX_W'(ROW_BANDS - 1))
                            row_idx_next = row_idx_reg + 1'b1;
                    end
                end
                else
                begin
                    y_pos_next   = '0;
                    y_band_next  = '0;
                    row_idx_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_pos_reg   <= '0;
            x_band_reg  <= '0;
            col_idx_reg <= '0;
            y_pos_reg   <= '0;
            y_band_reg  <= '0;
            row_idx_reg <= '0;
        end
        else
        begin
            x_pos_reg   <= x_pos_next;
            x_band_reg  <= x_band_next;
            col_idx_reg <= col_idx_next;
            y_pos_reg   <= y_pos_next;
            y_band_reg  <= y_band_next;
            row_idx_reg <= row_idx_next;
        end
    end

endmodule

>>> rtl/fdbl_accum.sv
// ----------------------------------------------------------------------------
// fdbl_accum
// Band sum memories with read-modify-write, write forwarding, per-entry valid
// bits for the frame clear, and running winner trackers for both band sets.
// ----------------------------------------------------------------------------
module fdbl_accum
    import fdbl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      acc_valid,
    input  scan_pos_t acc_pos,
    input  pix_t      acc_diff,
    output logic      res_push,
    output res_t      res_data
);

    // Stage 1 registers
    logic     s1_valid_reg;
    logic     s1_last_reg;
    col_idx_t s1_col_reg;
    row_idx_t s1_row_reg;
    pix_t     s1_diff_reg;

    // Entry valid bits: cleared at frame end instead of sweeping the memories
    logic [COL_BANDS-1:0] col_vld_reg;
    logic [ROW_BANDS-1:0] row_vld_reg;

    // Last write, for a read that raced it
    logic     cf_valid_reg, rf_valid_reg;
    col_idx_t cf_idx_reg;
    row_idx_t rf_idx_reg;
    sum_t     cf_data_reg, rf_data_reg;

    // Running winners: lowest index holding the greatest sum
    col_idx_t best_col_reg, best_col_next;
    row_idx_t best_row_reg, best_row_next;
    sum_t     best_cval_reg, best_cval_next;
    sum_t     best_rval_reg, best_rval_next;

    sum_t col_rd, row_rd;
    sum_t col_old, row_old;
    sum_t col_new, row_new;
    logic [SUM_WIDTH:0] col_sum, row_sum;

    fdbl_ram #(
        .WIDTH (SUM_WIDTH),
        .DEPTH (COL_BANDS)
    ) u_col_ram (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (col_new),
        .rd_en   (acc_valid),
        .rd_addr (acc_pos.col_idx),
        .rd_data (col_rd)
    );

    fdbl_ram #(
        .WIDTH (SUM_WIDTH),
        .DEPTH (ROW_BANDS)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_row_reg),
        .wr_data (row_new),
        .rd_en   (acc_valid),
        .rd_addr (acc_pos.row_idx),
        .rd_data (row_rd)
    );

    // Pick the current sum: forwarded write, stored entry, or cleared
    always_comb
    begin
        if (cf_valid_reg && (cf_idx_reg == s1_col_reg))
            col_old = cf_data_reg;
        else if (col_vld_reg[s1_col_reg])
            col_old = col_rd;
        else
            col_old = '0;

        if (rf_valid_reg && (rf_idx_reg == s1_row_reg))
            row_old = rf_data_reg;
        else if (row_vld_reg[s1_row_reg])
            row_old = row_rd;
        else
            row_old = '0;
    end

    // Saturating add
    assign col_sum = {1'b0, col_old} + (SUM_WIDTH + 1)'(s1_diff_reg);
    assign row_sum = {1'b0, row_old} + (SUM_WIDTH + 1)'(s1_diff_reg);
    assign col_new = col_sum[SUM_WIDTH] ? '1 : col_sum[SUM_WIDTH-1:0];
    assign row_new = row_sum[SUM_WIDTH] ? '1 : row_sum[SUM_WIDTH-1:0];

    // Update the winners with the entry just written
    always_comb
    begin
        best_col_next  = best_col_reg;
        best_cval_next = best_cval_reg;
        if (s1_col_reg == best_col_reg)
            best_cval_next = col_new;
        else if ((col_new > best_cval_reg) ||
                 ((col_new == best_cval_reg) && (s1_col_reg < best_col_reg)))
        begin
            best_col_next  = s1_col_reg;
            best_cval_next = col_new;
        end

        best_row_next  = best_row_reg;
        best_rval_next = best_rval_reg;
        if (s1_row_reg == best_row_reg)
            best_rval_next = row_new;
        else if ((row_new > best_rval_reg) ||
                 ((row_new == best_rval_reg) && (s1_row_reg < best_row_reg)))
        begin
            best_row_next  = s1_row_reg;
            best_rval_next = row_new;
        end
    end

    // Emit the result on the last pixel of the frame
    assign res_push               = s1_valid_reg && s1_last_reg;
    assign res_data.best_col_band = OUT_COL_W'({1'b0, best_col_next} + 1'b1);
    assign res_data.best_row_band = OUT_ROW_W'({1'b0, best_row_next} + 1'b1);
    assign res_data.best_col_sum  = to_out_sum(best_cval_next);
    assign res_data.best_row_sum  = to_out_sum(best_rval_next);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            col_vld_reg   <= '0;
            row_vld_reg   <= '0;
            cf_valid_reg  <= 1'b0;
            rf_valid_reg  <= 1'b0;
            best_col_reg  <= '0;
            best_row_reg  <= '0;
            best_cval_reg <= '0;
            best_rval_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= acc_valid;
            if (s1_valid_reg)
            begin
                if (s1_last_reg)
                begin
                    // Start a fresh frame: all sums read as zero
                    col_vld_reg   <= '0;
                    row_vld_reg   <= '0;
                    cf_valid_reg  <= 1'b0;
                    rf_valid_reg  <= 1'b0;
                    best_col_reg  <= '0;
                    best_row_reg  <= '0;
                    best_cval_reg <= '0;
                    best_rval_reg <= '0;
                end
                else
                begin
                    col_vld_reg[s1_col_reg] <= 1'b1;
                    row_vld_reg[s1_row_reg] <= 1'b1;
                    cf_valid_reg  <= 1'b1;
                    rf_valid_reg  <= 1'b1;
                    best_col_reg  <= best_col_next;
                    best_row_reg  <= best_row_next;
                    best_cval_reg <= best_cval_next;
                    best_rval_reg <= best_rval_next;
                end
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (acc_valid)
        begin
            s1_last_reg <= acc_pos.frame_end;
            s1_col_reg  <= acc_pos.col_idx;
            s1_row_reg  <= acc_pos.row_idx;
            s1_diff_reg <= acc_diff;
        end
        if (s1_valid_reg)
        begin
            cf_idx_reg  <= s1_col_reg;
            cf_data_reg <= col_new;
            rf_idx_reg  <= s1_row_reg;
            rf_data_reg <= row_new;
        end
    end

endmodule

>>> verif/tb_frame_difference_band_locator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_difference_band_locator_core
// Streams pixel pairs through the band locator in bursts while the result
// side stalls at random. Each accepted pixel is run through a local band
// accumulator that predicts the per-frame winner, and each result item is
// checked field by field against the oldest prediction. The frame geometry
// is reprogrammed over APB between phases, covering one-pixel frames, band
// folding on both axes and clamped register values.
// ----------------------------------------------------------------------------
module tb_frame_difference_band_locator_core;
    import fdbl_pkg::*;

    typedef struct packed {
        pix_t cur;
        pix_t prev;
    } pixel_pair_t;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    typedef enum int {
        FRAME_NOISE,
        FRAME_STILL,
        FRAME_SPARSE
    } frame_style_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  pix_valid  = 1'b0;
    logic                  pix_stall;
    logic [PIX_W-1:0]      cur_pixel  = '0;
    logic [PIX_W-1:0]      prev_pixel = '0;
    logic                  res_valid;
    logic                  res_stall  = 1'b0;
    logic [OUT_COL_W-1:0]  best_col_band;
    logic [OUT_ROW_W-1:0]  best_row_band;
    logic [OUT_SUM_W-1:0]  best_col_sum;
    logic [OUT_SUM_W-1:0]  best_row_sum;

    // Pixel pairs waiting to be sent, and predicted band winners per frame
    pixel_pair_t pixel_queue[$];
    res_t        pending_band_results[$];

    // Local copy of the configuration, indexed by register code
    dim_t cfg_regs[4] = '{FRAME_WIDTH_RST, FRAME_HEIGHT_RST,
                          COL_BAND_WIDTH_RST, ROW_BAND_HEIGHT_RST};

    // Local scan position and band sums
    pos_t     col_pos     = '0;
    pos_t     col_offset  = '0;
    col_idx_t col_band    = '0;
    pos_t     line_pos    = '0;
    pos_t     line_offset = '0;
    row_idx_t line_band   = '0;
    sum_t     col_sums[COL_BANDS];
    sum_t     row_sums[ROW_BANDS];

    int          mismatch_count = 0;
    int          queued_pixels  = 0;
    int          queued_frames  = 0;
    int          burst_left     = 0;
    int          gap_left       = 0;
    int          cycle_count    = 0;
    stall_mode_t stall_mode     = STALL_NONE;
    pixel_pair_t next_pair;
    res_t        want;

    frame_difference_band_locator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .pix_valid     (pix_valid),
        .pix_stall     (pix_stall),
        .cur_pixel     (cur_pixel),
        .prev_pixel    (prev_pixel),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .best_col_band (best_col_band),
        .best_row_band (best_row_band),
        .best_col_sum  (best_col_sum),
        .best_row_sum  (best_row_sum)
    );

    always #10 clk = ~clk;

    initial
    begin
        foreach (col_sums[i]) col_sums[i] = '0;
        foreach (row_sums[i]) row_sums[i] = '0;
    end

    // Zero reads as one, anything past the maximum reads as the maximum
    function automatic int clamped_dim(input dim_t value);
        if (value == '0)
            return 1;
        if (value > DIM_MAX)
            return int'(DIM_MAX);
        return int'(value);
    endfunction

    function automatic sum_t saturating_add(input sum_t acc, input pix_t delta);
        logic [SUM_WIDTH:0] wide;
        wide = {1'b0, acc} + (SUM_WIDTH + 1)'(delta);
        return wide[SUM_WIDTH] ? '1 : wide[SUM_WIDTH-1:0];
    endfunction

    function automatic logic [OUT_SUM_W-1:0] reported_sum(input sum_t acc);
        logic [63:0] wide;
        wide = 64'(acc);
        return (wide > 64'hFFFF_FFFF) ? '1 : wide[OUT_SUM_W-1:0];
    endfunction

    // Add one pixel difference to its bands; predict the winners at frame end
    task automatic accumulate_pixel(input pix_t cur, input pix_t prev);
        pix_t delta;
        int   frame_w;
        int   frame_h;
        int   col_span;
        int   row_span;
        int   ci;
        int   ri;
        int   bc;
        int   br;
        res_t outcome;
        delta    = (cur >= prev) ? pix_t'(cur - prev) : pix_t'(prev - cur);
        frame_w  = clamped_dim(cfg_regs[REG_FRAME_WIDTH]);
        frame_h  = clamped_dim(cfg_regs[REG_FRAME_HEIGHT]);
        col_span = clamped_dim(cfg_regs[REG_COL_BAND_WIDTH]);
        row_span = clamped_dim(cfg_regs[REG_ROW_BAND_HEIGHT]);
        ci = (int'(col_band) < COL_BANDS) ? int'(col_band) : COL_BANDS - 1;
        ri = (int'(line_band) < ROW_BANDS) ? int'(line_band) : ROW_BANDS - 1;

        col_sums[ci] = saturating_add(col_sums[ci], delta);
        row_sums[ri] = saturating_add(row_sums[ri], delta);

        // Advance along the line
        if (int'(col_pos) + 1 < frame_w)
        begin
            col_pos++;
            if (int'(col_offset) + 1 < col_span)
                col_offset++;
            else
            begin
                col_offset = '0;
                col_band   = (ci + 1 < COL_BANDS) ? col_idx_t'(ci + 1) : col_idx_t'(ci);
            end
            return;
        end
        col_pos    = '0;
        col_offset = '0;
        col_band   = '0;

        // Advance to the next line
        if (int'(line_pos) + 1 < frame_h)
        begin
            line_pos++;
            if (int'(line_offset) + 1 < row_span)
                line_offset++;
            else
            begin
                line_offset = '0;
                line_band   = (ri + 1 < ROW_BANDS) ? row_idx_t'(ri + 1) : row_idx_t'(ri);
            end
            return;
        end
        line_pos    = '0;
        line_offset = '0;
        line_band   = '0;

        // Frame done: first band wins a tie
        bc = 0;
        br = 0;
        for (int i = 1; i < COL_BANDS; i++)
            if (col_sums[i] > col_sums[bc])
                bc = i;
        for (int i = 1; i < ROW_BANDS; i++)
            if (row_sums[i] > row_sums[br])
                br = i;
        outcome.best_col_band = OUT_COL_W'(bc + 1);
        outcome.best_row_band = OUT_ROW_W'(br + 1);
        outcome.best_col_sum  = reported_sum(col_sums[bc]);
        outcome.best_row_sum  = reported_sum(row_sums[br]);
        pending_band_results.insert(pending_band_results.size(), outcome);
        foreach (col_sums[i]) col_sums[i] = '0;
        foreach (row_sums[i]) row_sums[i] = '0;
    endtask

    // Pixel driver: bursts of random length separated by random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_valid && !pix_stall)
                accumulate_pixel(cur_pixel, prev_pixel);
            if (!pix_valid || !pix_stall)
            begin
                if (gap_left != 0)
                begin
                    pix_valid <= 1'b0;
                    gap_left--;
                end
                else if (pixel_queue.size() != 0)
                begin
                    next_pair  = pixel_queue.pop_front();
                    pix_valid  <= 1'b1;
                    cur_pixel  <= next_pair.cur;
                    prev_pixel <= next_pair.prev;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 300 : 16);
                        gap_left   = $urandom_range(0, 6);
                    end
                    else
                        burst_left--;
                end
                else
                    pix_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check against the oldest prediction, stall on a pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (pending_band_results.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: unexpected result: col %0d row %0d sums %0d %0d",
                                 $time, best_col_band, best_row_band,
                                 best_col_sum, best_row_sum);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_band_results.pop_front();
                    if (best_col_band !== want.best_col_band ||
                        best_row_band !== want.best_row_band ||
                        best_col_sum  !== want.best_col_sum  ||
                        best_row_sum  !== want.best_row_sum)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("%0t: mismatch: expected col %0d row %0d sums %0d %0d",
                                     $time, want.best_col_band, want.best_row_band,
                                     want.best_col_sum, want.best_row_sum);
                            $display("%0t:           got col %0d row %0d sums %0d %0d",
                                     $time, best_col_band, best_row_band,
                                     best_col_sum, best_row_sum);
                        end
                        mismatch_count++;
                    end
                end
            end

            // Pick the stall pattern at random and drive res_stall from it
            cycle_count++;
            if (cycle_count % 64 == 0)
                stall_mode = stall_mode_t'($urandom_range(0, 3));
            case (stall_mode)
                STALL_NONE:     res_stall <= 1'b0;
                STALL_HALF:     res_stall <= 1'($urandom_range(0, 1));
                STALL_HEAVY:    res_stall <= ($urandom_range(0, 7) != 0);
                STALL_PERIODIC: res_stall <= (cycle_count % 8 >= 5);
                default:        res_stall <= 1'b0;
            endcase
        end
    end

    // Hold until every pixel is accepted and every result has come back
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (pixel_queue.size() != 0 || pix_valid || pending_band_results.size() != 0);
    endtask

    task automatic write_register(input logic [1:0] reg_index, input dim_t value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({reg_index, 2'b00});
        pwdata  <= {(APB_DATA_W - DIM_W)'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_regs[reg_index] = value;
    endtask

    // Drain, let the pipeline settle, then reprogram the frame geometry
    task automatic program_config(input dim_t frame_w, input dim_t frame_h,
                                  input dim_t col_span, input dim_t row_span);
        wait_for_drain();
        repeat (4) @(posedge clk);
        write_register(REG_FRAME_WIDTH, frame_w);
        write_register(REG_FRAME_HEIGHT, frame_h);
        write_register(REG_COL_BAND_WIDTH, col_span);
        write_register(REG_ROW_BAND_HEIGHT, row_span);
    endtask

    // Queue whole frames at the current geometry with random content
    task automatic queue_frames(input int count);
        int           pixels;
        frame_style_t style;
        pixel_pair_t  pair;
        pixels = clamped_dim(cfg_regs[REG_FRAME_WIDTH]) *
                 clamped_dim(cfg_regs[REG_FRAME_HEIGHT]);
        repeat (count)
        begin
            style = frame_style_t'($urandom_range(0, 2));
            for (int n = 0; n < pixels; n++)
            begin
                pair.cur = pix_t'($urandom);
                case (style)
                    FRAME_STILL:  pair.prev = pair.cur;
                    FRAME_SPARSE: pair.prev = ($urandom_range(0, 7) == 0) ?
                                              pix_t'($urandom) : pair.cur;
                    default:      pair.prev = pix_t'($urandom);
                endcase
                pixel_queue.insert(pixel_queue.size(), pair);
            end
            queued_pixels += pixels;
            queued_frames++;
        end
    endtask

    function automatic dim_t pick_extent(input int max_extent);
        return ($urandom_range(0, 9) == 0) ? dim_t'(0) : dim_t'($urandom_range(1, max_extent));
    endfunction

    function automatic dim_t pick_span();
        case ($urandom_range(0, 9))
            0:       return dim_t'(0);
            1:       return DIM_MAX;
            2:       return '1;
            3:       return dim_t'($urandom);
            default: return dim_t'($urandom_range(1, 6));
        endcase
    endfunction

    // Stimulus
    initial
    begin
        int start_frames;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // One-pixel frames: every register zero, pixel extremes both ways
        program_config('0, '0, '0, '0);
        pixel_queue.insert(pixel_queue.size(), {8'h00, 8'h00});
        pixel_queue.insert(pixel_queue.size(), {8'hFF, 8'h00});
        pixel_queue.insert(pixel_queue.size(), {8'h00, 8'hFF});
        pixel_queue.insert(pixel_queue.size(), {8'hFF, 8'hFF});
        pixel_queue.insert(pixel_queue.size(), {8'hAA, 8'h55});
        pixel_queue.insert(pixel_queue.size(), {8'h55, 8'hAA});
        queued_pixels += 6;
        queued_frames += 6;

        // One-column bands past the built count fold into the last band
        program_config(13'd18, '0, 13'd1, '1);
        queue_frames(1);

        // One-line bands past the built count fold into the last band
        program_config(13'd2, 13'd12, '1, 13'd1);
        queue_frames(2);

        // Random geometry, a few frames per setting
        start_frames = queued_frames;
        while (queued_pixels < 1150 || queued_frames - start_frames < 20)
        begin
            program_config(pick_extent(16), pick_extent(10), pick_span(), pick_span());
            queue_frames($urandom_range(1, 4));
        end

        wait_for_drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_band_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
